// ===== sv/hbtt_pkg.sv =====
// ----------------------------------------------------------------------------
// hbtt_pkg
// Shared types and constants for the heartbeat timeout table.
// ----------------------------------------------------------------------------
package hbtt_pkg;

   // field widths of the stream words
   localparam int unsigned CMD_W        = 3;
   localparam int unsigned NODE_W       = 4;
   localparam int unsigned NOW_W        = 32;
   localparam int unsigned PERIOD_W     = 32;
   localparam int unsigned REQ_DATA_W   = 40;
   localparam int unsigned RSP_DATA_W   = 8;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000;

   typedef enum logic [CMD_W-1:0] {
      CMD_TRACK     = 3'd0,
      CMD_UNTRACK   = 3'd1,
      CMD_HEARTBEAT = 3'd2,
      CMD_CHECK     = 3'd3,
      CMD_QUERY     = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_PRESENT   = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;

   // result word, packed so that status sits in the lowest bits
   typedef struct packed {
      logic [NODE_W-1:0] failed_node;
      logic              failed;
      logic              tracking;
      status_type        status;
   } rsp_word_type;

endpackage

// ===== sv/heartbeat_timeout_table_top.sv =====
// ----------------------------------------------------------------------------
// heartbeat_timeout_table_top
// Heartbeat failure detector over a table of watched nodes, indexed by node
// number, with a sequenced timeout sweep over a timestamp memory.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | contents
//  ---------+-----------+----------------------+------------------------------
//  req_     | in        | tvalid/tready        | tuser: command; tdata: node, now
//  rsp_     | out       | tvalid/tready, tlast | tdata: status, tracking,
//           |           |                      |   failed, failed_node
//  csr_     | in        | wr_en only           | timeout period in ticks
//
// Track, untrack, heartbeat and query need no sweep: the word is accepted
// and its result sits in the output register on the next cycle.
// A check walks the table through the single read port of the timestamp
// memory with one shared subtract/compare unit: a read state and a compare
// state per node, then a done state that sends the terminal word.
// req_tready is low during a sweep and while an unaccepted result blocks the
// output register; a stalled rsp_ side holds the sweep on its current node.
// Reset (synchronous) clears the valid and dead marks and loads the period
// with 1000; the timestamp memory is not cleared (no clearing pass).
//
module heartbeat_timeout_table_top #(
   parameter int NODES     = 16,
   parameter int TIME_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [3:0] node, [35:4] now, [39:36] zero
   input  logic [hbtt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] command
   input  logic [hbtt_pkg::CMD_W-1:0]       req_tuser,

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] status, [2] tracking, [3] failed, [7:4] failed_node
   output logic [hbtt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,

   input  logic                             csr_wr_en,
   input  logic [hbtt_pkg::PERIOD_W-1:0]    csr_wr_data
);

   localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CMP_W = (TIME_BITS > int'(hbtt_pkg::PERIOD_W)) ?
                          TIME_BITS : int'(hbtt_pkg::PERIOD_W);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NODES - 1);

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   hbtt_pkg::state_type             state_ff, state_in;
   logic [hbtt_pkg::PERIOD_W-1:0]   period_ff;
   logic [NODES-1:0]                valid_ff, valid_in;
   logic [NODES-1:0]                dead_ff, dead_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic [TIME_BITS-1:0]            now_ff, now_in;
   logic [TIME_BITS-1:0]            heard_rd_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   hbtt_pkg::rsp_word_type          rsp_word_ff, rsp_word_in;
   logic                            rsp_last_ff, rsp_last_in;

   // timestamp store, one entry per node, undefined until written
   logic [TIME_BITS-1:0]            heard_mem [NODES];

   // ---------------------------------------------------------------------
   // request decode
   // ---------------------------------------------------------------------
   hbtt_pkg::cmd_type               req_cmd;
   logic [hbtt_pkg::NODE_W-1:0]     req_node;
   logic [hbtt_pkg::NOW_W-1:0]      req_now;
   logic [CMP_W-1:0]                req_now_wide;
   logic [IDX_W-1:0]                node_idx;
   logic                            in_table;
   logic                            hit;
   logic                            req_fire;
   logic                            out_free;

   assign req_cmd      = hbtt_pkg::cmd_type'(req_tuser);
   assign req_node     = req_tdata[hbtt_pkg::NODE_W-1:0];
   assign req_now      = req_tdata[hbtt_pkg::NODE_W +: hbtt_pkg::NOW_W];
   assign req_now_wide = CMP_W'(req_now);
   assign node_idx     = IDX_W'(req_node);
   assign in_table     = ({{(32 - hbtt_pkg::NODE_W){1'b0}}, req_node} < 32'(NODES));
   assign hit          = in_table && valid_ff[node_idx];

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_fire     = req_tvalid && req_tready;

   // ---------------------------------------------------------------------
   // shared subtract/compare: wrap-around elapsed time vs period
   // ---------------------------------------------------------------------
   logic [TIME_BITS-1:0]            elapsed;
   logic                            late;
   logic                            dead_now;
   logic                            emit_fail;

   assign elapsed   = now_ff - heard_rd_ff;
   assign late      = CMP_W'(elapsed) > CMP_W'(period_ff);
   assign dead_now  = dead_ff[idx_ff] || late;
   assign emit_fail = valid_ff[idx_ff] && dead_now;

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hbtt_pkg::ST_IDLE: begin
            if (req_fire && req_cmd == hbtt_pkg::CMD_CHECK) begin
               state_in = hbtt_pkg::ST_READ;
            end
         end
         hbtt_pkg::ST_READ: begin
            state_in = hbtt_pkg::ST_CMP;
         end
         hbtt_pkg::ST_CMP: begin
            if (!emit_fail || out_free) begin
               state_in = (idx_ff == IDX_LAST) ? hbtt_pkg::ST_DONE : hbtt_pkg::ST_READ;
            end
         end
         hbtt_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = hbtt_pkg::ST_IDLE;
            end
         end
         default: state_in = hbtt_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // outputs and datapath controls
   // ---------------------------------------------------------------------
   logic                            mem_we;
   logic                            load_rsp;

   always_comb begin
      req_tready  = 1'b0;
      mem_we      = 1'b0;
      load_rsp    = 1'b0;
      valid_in    = valid_ff;
      dead_in     = dead_ff;
      idx_in      = idx_ff;
      now_in      = now_ff;
      rsp_word_in = '0;
      rsp_last_in = 1'b1;

      unique case (state_ff)
         hbtt_pkg::ST_IDLE: begin
            req_tready = out_free;
            if (req_fire) begin
               unique case (req_cmd)
                  hbtt_pkg::CMD_TRACK: begin
                     load_rsp = 1'b1;
                     if (!in_table) begin
                        rsp_word_in.status = hbtt_pkg::STATUS_NOT_FOUND;
                     end else if (hit) begin
                        rsp_word_in.status = hbtt_pkg::STATUS_PRESENT;
                     end else begin
                        mem_we             = 1'b1;
                        valid_in[node_idx] = 1'b1;
                        dead_in[node_idx]  = 1'b0;
                     end
                  end
                  hbtt_pkg::CMD_UNTRACK: begin
                     load_rsp = 1'b1;
                     if (hit) begin
                        valid_in[node_idx] = 1'b0;
                        dead_in[node_idx]  = 1'b0;
                     end else begin
                        rsp_word_in.status = hbtt_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  hbtt_pkg::CMD_HEARTBEAT: begin
                     load_rsp = 1'b1;
                     if (hit) begin
                        mem_we            = 1'b1;
                        dead_in[node_idx] = 1'b0;
                     end else begin
                        rsp_word_in.status = hbtt_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  hbtt_pkg::CMD_CHECK: begin
                     idx_in = '0;
                     now_in = req_now_wide[TIME_BITS-1:0];
                  end
                  hbtt_pkg::CMD_QUERY: begin
                     load_rsp             = 1'b1;
                     rsp_word_in.tracking = hit;
                  end
                  default: begin
                     // unused codes: plain terminal word
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         hbtt_pkg::ST_READ: begin
         end
         hbtt_pkg::ST_CMP: begin
            if (!emit_fail || out_free) begin
               if (valid_ff[idx_ff]) begin
                  dead_in[idx_ff] = dead_now;
               end
               idx_in = idx_ff + IDX_W'(1);
               if (emit_fail) begin
                  load_rsp                = 1'b1;
                  rsp_last_in             = 1'b0;
                  rsp_word_in.failed      = 1'b1;
                  rsp_word_in.failed_node = hbtt_pkg::NODE_W'(idx_ff);
               end
            end
         end
         hbtt_pkg::ST_DONE: begin
            load_rsp = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hbtt_pkg::ST_IDLE;
         period_ff    <= hbtt_pkg::PERIOD_RESET;
         valid_ff     <= '0;
         dead_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         dead_ff      <= dead_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      now_ff <= now_in;
      if (load_rsp) begin
         rsp_word_ff <= rsp_word_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   // timestamp memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         heard_mem[node_idx] <= req_now_wide[TIME_BITS-1:0];
      end
      heard_rd_ff <= heard_mem[idx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
